### rtl/sorted_linked_table_with_free_list_assert.svh
// Assertion macros for the sorted linked table.
`ifndef SORTED_LINKED_TABLE_WITH_FREE_LIST_ASSERT_SVH
`define SORTED_LINKED_TABLE_WITH_FREE_LIST_ASSERT_SVH

// Implication checked in the same cycle.
`define SLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define SLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/slt_pkg.sv
package slt_pkg;

    localparam int CAPACITY     = 128;
    localparam int KEY_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int SLOT_BITS    = $clog2(CAPACITY);
    localparam int IDX_BITS     = $clog2(CAPACITY + 1);
    localparam int COUNT_BITS   = 8;
    localparam int WORD_BITS    = KEY_BITS + PAYLOAD_BITS;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_CHANGE = 2'd2;
    localparam mode_t MODE_CLEAR  = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_DONE      = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_EMPTY     = 2'd2;
    localparam status_t STATUS_FULL      = 2'd3;

    typedef logic [IDX_BITS-1:0] idx_t;
    localparam idx_t NIL = IDX_BITS'(CAPACITY);

endpackage

### rtl/slt_if.sv
interface slt_req_if import slt_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic [1:0]                     mode;
    logic signed [KEY_BITS-1:0]     key;
    logic signed [KEY_BITS-1:0]     new_key;
    logic [PAYLOAD_BITS-1:0]        payload;

    modport source (output valid, mode, key, new_key, payload, input ready);
    modport sink   (input valid, mode, key, new_key, payload, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             status;
    logic [COUNT_BITS-1:0]  count;
    logic                   is_full;
    logic                   is_empty;

    modport source (output valid, status, count, is_full, is_empty, input ready);
    modport sink   (input valid, status, count, is_full, is_empty, output ready);
endinterface

### rtl/slt_ram.sv
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/sorted_linked_table_with_free_list.sv
// Sorted linked table with free list.
// req (sink): one transaction per command: mode, key, new_key, payload.
//   Insert, delete by key, change key, clear table.
// rsp (source): one transaction per command: status, count, is_full, is_empty.
// Records live in a key/payload RAM and a link RAM, both with registered read.
// Records are chained in ascending signed key order; free slots in a second chain.
// A chain walk visits one record at a time; insert walks to its place, delete
//   walks to its key, change finds the key, then reinserts with the new key.
//   Clear sweeps the link RAM; refused commands go straight to the response.
//   One command is in work at a time, and the next is accepted in the cycle
//   after the result is loaded.
// Reset: a sweep of the link RAM relinks the free chain; req.ready stays low.
// Result sits in an output register; the next command is accepted while it
// waits. If rsp stalls, a finished command holds until the register drains.
module sorted_linked_table_with_free_list import slt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    slt_req_if.sink  req,
    slt_rsp_if.source rsp
);

`include "sorted_linked_table_with_free_list_assert.svh"

    typedef enum logic [13:0] {
        ST_INIT   = 14'b00000000000001,
        ST_IDLE   = 14'b00000000000010,
        ST_IPOP   = 14'b00000000000100,
        ST_IWR    = 14'b00000000001000,
        ST_LREQ   = 14'b00000000010000,
        ST_LCHK   = 14'b00000000100000,
        ST_LFIN1  = 14'b00000001000000,
        ST_LFIN2  = 14'b00000010000000,
        ST_FREQ   = 14'b00000100000000,
        ST_FCHK   = 14'b00001000000000,
        ST_UNLINK = 14'b00010000000000,
        ST_DFREE  = 14'b00100000000000,
        ST_CWR    = 14'b01000000000000,
        ST_RESP   = 14'b10000000000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [SLOT_BITS-1:0]       sweep_reg, sweep_next;
    logic                       clr_reg, clr_next;
    idx_t                       head_reg, head_next;
    idx_t                       free_reg, free_next;
    idx_t                       count_reg, count_next;
    idx_t                       cur_reg, cur_next;
    idx_t                       prev_reg, prev_next;
    idx_t                       slot_reg, slot_next;
    idx_t                       nxt_reg, nxt_next;
    status_t                    status_reg, status_next;
    logic                       ovalid_reg, ovalid_next;
    status_t                    ostatus_reg, ostatus_next;
    idx_t                       ocount_reg, ocount_next;

    mode_t                      mode_reg, mode_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic signed [KEY_BITS-1:0] nkey_reg, nkey_next;
    logic signed [KEY_BITS-1:0] tgt_reg, tgt_next;
    logic [PAYLOAD_BITS-1:0]    pay_reg, pay_next;

    logic                       kram_we;
    logic [SLOT_BITS-1:0]       kram_waddr;
    logic [WORD_BITS-1:0]       kram_wdata;
    logic [WORD_BITS-1:0]       kram_rdata;
    logic                       lram_we;
    logic [SLOT_BITS-1:0]       lram_waddr;
    idx_t                       lram_wdata;
    idx_t                       lram_rdata;
    logic [SLOT_BITS-1:0]       raddr;
    logic signed [KEY_BITS-1:0] key_rd;
    logic                       accept;

    slt_ram #(.WIDTH(WORD_BITS), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (kram_we),
        .waddr (kram_waddr),
        .wdata (kram_wdata),
        .raddr (raddr),
        .rdata (kram_rdata)
    );

    slt_ram #(.WIDTH(IDX_BITS), .DEPTH(CAPACITY)) u_link_ram (
        .clk   (clk),
        .we    (lram_we),
        .waddr (lram_waddr),
        .wdata (lram_wdata),
        .raddr (raddr),
        .rdata (lram_rdata)
    );

    assign key_rd    = $signed(kram_rdata[WORD_BITS-1 -: KEY_BITS]);
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid    = ovalid_reg;
    assign rsp.status   = ostatus_reg;
    assign rsp.count    = COUNT_BITS'(ocount_reg);
    assign rsp.is_full  = (ocount_reg == IDX_BITS'(CAPACITY));
    assign rsp.is_empty = (ocount_reg == '0);

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        free_next    = free_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        slot_next    = slot_reg;
        nxt_next     = nxt_reg;
        status_next  = status_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        ocount_next  = ocount_reg;
        mode_next    = mode_reg;
        key_next     = key_reg;
        nkey_next    = nkey_reg;
        tgt_next     = tgt_reg;
        pay_next     = pay_reg;

        kram_we    = 1'b0;
        kram_waddr = slot_reg[SLOT_BITS-1:0];
        kram_wdata = {key_reg, pay_reg};
        lram_we    = 1'b0;
        lram_waddr = slot_reg[SLOT_BITS-1:0];
        lram_wdata = cur_reg;
        raddr      = cur_reg[SLOT_BITS-1:0];

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                lram_we    = 1'b1;
                lram_waddr = sweep_reg;
                lram_wdata = IDX_BITS'(sweep_reg) + IDX_BITS'(1);
                sweep_next = sweep_reg + SLOT_BITS'(1);
                if (sweep_reg == SLOT_BITS'(CAPACITY - 1))
                begin
                    sweep_next  = '0;
                    head_next   = NIL;
                    free_next   = '0;
                    count_next  = '0;
                    status_next = STATUS_DONE;
                    clr_next    = 1'b0;
                    state_next  = clr_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = mode_t'(req.mode);
                    key_next  = req.key;
                    nkey_next = req.new_key;
                    pay_next  = req.payload;
                    tgt_next  = req.key;
                    cur_next  = head_reg;
                    prev_next = NIL;
                    slot_next = free_reg;
                    case (mode_t'(req.mode))
                        MODE_INSERT:
                        begin
                            if (count_reg == IDX_BITS'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_IPOP;
                            end
                        end
                        MODE_DELETE, MODE_CHANGE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_FREQ;
                            end
                        end
                        default:
                        begin
                            clr_next   = 1'b1;
                            sweep_next = '0;
                            state_next = ST_INIT;
                        end
                    endcase
                end
            end
            ST_IPOP:
            begin
                raddr      = slot_reg[SLOT_BITS-1:0];
                state_next = ST_IWR;
            end
            ST_IWR:
            begin
                free_next  = lram_rdata;
                kram_we    = 1'b1;
                state_next = ST_LREQ;
            end
            ST_LREQ:
            begin
                state_next = (cur_reg == NIL) ? ST_LFIN1 : ST_LCHK;
            end
            ST_LCHK:
            begin
                if (key_rd < tgt_reg)
                begin
                    prev_next  = cur_reg;
                    cur_next   = lram_rdata;
                    state_next = ST_LREQ;
                end
                else
                begin
                    state_next = ST_LFIN1;
                end
            end
            ST_LFIN1:
            begin
                lram_we    = 1'b1;
                state_next = ST_LFIN2;
            end
            ST_LFIN2:
            begin
                if (prev_reg != NIL)
                begin
                    lram_we    = 1'b1;
                    lram_waddr = prev_reg[SLOT_BITS-1:0];
                    lram_wdata = slot_reg;
                end
                else
                begin
                    head_next = slot_reg;
                end
                if (mode_reg == MODE_INSERT)
                begin
                    count_next = count_reg + IDX_BITS'(1);
                end
                status_next = STATUS_DONE;
                state_next  = ST_RESP;
            end
            ST_FREQ:
            begin
                if (cur_reg == NIL)
                begin
                    status_next = STATUS_NOT_FOUND;
                    state_next  = ST_RESP;
                end
                else
                begin
                    state_next = ST_FCHK;
                end
            end
            ST_FCHK:
            begin
                if (key_rd == key_reg)
                begin
                    slot_next  = cur_reg;
                    nxt_next   = lram_rdata;
                    pay_next   = kram_rdata[PAYLOAD_BITS-1:0];
                    state_next = ST_UNLINK;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = lram_rdata;
                    state_next = ST_FREQ;
                end
            end
            ST_UNLINK:
            begin
                if (prev_reg != NIL)
                begin
                    lram_we    = 1'b1;
                    lram_waddr = prev_reg[SLOT_BITS-1:0];
                    lram_wdata = nxt_reg;
                end
                else
                begin
                    head_next = nxt_reg;
                end
                state_next = (mode_reg == MODE_DELETE) ? ST_DFREE : ST_CWR;
            end
            ST_DFREE:
            begin
                lram_we     = 1'b1;
                lram_wdata  = free_reg;
                free_next   = slot_reg;
                count_next  = count_reg - IDX_BITS'(1);
                status_next = STATUS_DONE;
                state_next  = ST_RESP;
            end
            ST_CWR:
            begin
                kram_we    = 1'b1;
                kram_wdata = {nkey_reg, pay_reg};
                tgt_next   = nkey_reg;
                cur_next   = head_reg;
                prev_next  = NIL;
                state_next = ST_LREQ;
            end
            ST_RESP:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = status_reg;
                    ocount_next  = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            sweep_reg  <= '0;
            clr_reg    <= 1'b0;
            head_reg   <= NIL;
            free_reg   <= '0;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            clr_reg    <= clr_next;
            head_reg   <= head_next;
            free_reg   <= free_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        slot_reg    <= slot_next;
        nxt_reg     <= nxt_next;
        status_reg  <= status_next;
        ostatus_reg <= ostatus_next;
        ocount_reg  <= ocount_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        nkey_reg    <= nkey_next;
        tgt_reg     <= tgt_next;
        pay_reg     <= pay_next;
    end

    `SLT_ASSERT_NOW(a_count_range, 1'b1, count_reg <= IDX_BITS'(CAPACITY),
        "record count beyond capacity")
    `SLT_ASSERT_NOW(a_empty_chain, state_reg == ST_IDLE && count_reg == '0, head_reg == NIL,
        "empty table with a non-null head")
    `SLT_ASSERT_NOW(a_insert_room, state_reg == ST_IPOP, count_reg < IDX_BITS'(CAPACITY),
        "insert started on a full table")
    `SLT_ASSERT_NEXT(a_resp_load, state_reg == ST_RESP && (!ovalid_reg || rsp.ready),
        ovalid_reg && state_reg == ST_IDLE, "finished command not loaded into output")

endmodule

### dv/tb_sorted_linked_table_with_free_list.sv
module tb_sorted_linked_table_with_free_list;
    import slt_pkg::*;

    typedef struct packed {
        mode_t                          mode;
        logic signed [KEY_BITS-1:0]     key;
        logic signed [KEY_BITS-1:0]     new_key;
        logic [PAYLOAD_BITS-1:0]        payload;
    } command_t;

    typedef struct packed {
        status_t                status;
        logic [COUNT_BITS-1:0]  count;
        logic                   is_full;
        logic                   is_empty;
    } answer_t;

    typedef struct {
        command_t cmd;
        logic     has_answer;
        answer_t  answer;
    } row_t;

    logic clk;
    logic rst_n;
    slt_req_if req ();
    slt_rsp_if rsp ();

    sorted_linked_table_with_free_list i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Table model: the chain is kept as sorted lists of keys and payloads.
    logic signed [KEY_BITS-1:0]  tbl_key[$];
    logic [PAYLOAD_BITS-1:0]     tbl_payload[$];
    answer_t                     answer_queue[$];
    row_t                        rows[$];
    int                          mismatches;
    int                          checked;
    int                          cycle_count;
    int                          sent;
    int                          n_done, n_not_found, n_empty, n_full;
    logic                        stall_hold;
    logic                        quiet;

    function automatic void table_place(logic signed [KEY_BITS-1:0] k,
                                        logic [PAYLOAD_BITS-1:0] p);
        int pos;
        pos = 0;
        while (pos < tbl_key.size() && tbl_key[pos] < k)
            pos++;
        tbl_key.insert(pos, k);
        tbl_payload.insert(pos, p);
    endfunction

    function automatic answer_t table_apply(command_t c);
        answer_t a;
        int      pos;
        logic [PAYLOAD_BITS-1:0] p;
        a.status = STATUS_DONE;
        case (c.mode)
            MODE_INSERT:
            begin
                if (tbl_key.size() >= CAPACITY)
                    a.status = STATUS_FULL;
                else
                    table_place(c.key, c.payload);
            end
            MODE_DELETE, MODE_CHANGE:
            begin
                if (tbl_key.size() == 0)
                    a.status = STATUS_EMPTY;
                else
                begin
                    pos = 0;
                    while (pos < tbl_key.size() && tbl_key[pos] != c.key)
                        pos++;
                    if (pos == tbl_key.size())
                        a.status = STATUS_NOT_FOUND;
                    else
                    begin
                        p = tbl_payload[pos];
                        tbl_key.delete(pos);
                        tbl_payload.delete(pos);
                        if (c.mode == MODE_CHANGE)
                            table_place(c.new_key, p);
                    end
                end
            end
            default:
            begin
                tbl_key.delete();
                tbl_payload.delete();
            end
        endcase
        a.count    = COUNT_BITS'(tbl_key.size());
        a.is_full  = (tbl_key.size() == CAPACITY);
        a.is_empty = (tbl_key.size() == 0);
        return a;
    endfunction

    function automatic row_t make_row(mode_t m, logic [31:0] k, logic [31:0] nk,
                                      logic [31:0] p, logic chk, status_t s,
                                      int cnt);
        row_t r;
        r.cmd.mode    = m;
        r.cmd.key     = k;
        r.cmd.new_key = nk;
        r.cmd.payload = p;
        r.has_answer  = chk;
        r.answer.status   = s;
        r.answer.count    = COUNT_BITS'(cnt);
        r.answer.is_full  = (cnt == CAPACITY);
        r.answer.is_empty = (cnt == 0);
        return r;
    endfunction

    function automatic logic [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2 && tbl_key.size() > 0)
            return tbl_key[$urandom_range(0, tbl_key.size() - 1)];
        if (sel < 4)
            return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 3))}
                   | ($urandom_range(0, 1) ? 32'h7fff_fffc : 32'h0);
        if (sel < 8)
            return 32'($signed($urandom_range(0, 40)) - 20);
        return $urandom();
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_sorted_linked_table_with_free_list failed");
            $finish;
        end
    end

    task automatic send(command_t c);
        req.valid   <= 1'b1;
        req.mode    <= c.mode;
        req.key     <= c.key;
        req.new_key <= c.new_key;
        req.payload <= c.payload;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sent++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic predict_and_send(row_t r);
        answer_t a;
        a = table_apply(r.cmd);
        if (r.has_answer && a !== r.answer)
            $display("directed row %0d: table expectation %h disagrees with %h",
                     sent, r.answer, a);
        answer_queue.push_back(r.has_answer ? r.answer : a);
        send(r.cmd);
    endtask

    // Response side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (stall_hold || (!quiet && $urandom_range(0, 15) == 0))
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        answer_t got, want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status   = rsp.status;
            got.count    = rsp.count;
            got.is_full  = rsp.is_full;
            got.is_empty = rsp.is_empty;
            if (answer_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
            end
            else
            begin
                want = answer_queue.pop_front();
                checked++;
                case (got.status)
                    STATUS_DONE:      n_done++;
                    STATUS_NOT_FOUND: n_not_found++;
                    STATUS_EMPTY:     n_empty++;
                    default:          n_full++;
                endcase
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d: expected st=%0d cnt=%0d f=%b e=%b, got st=%0d cnt=%0d f=%b e=%b",
                                 checked, want.status, want.count, want.is_full, want.is_empty,
                                 got.status, got.count, got.is_full, got.is_empty);
                end
            end
        end
    end

    initial
    begin
        command_t c;
        int       mode_sel;
        req.valid   = 1'b0;
        req.mode    = MODE_INSERT;
        req.key     = '0;
        req.new_key = '0;
        req.payload = '0;
        stall_hold  = 1'b0;
        quiet       = 1'b0;
        mismatches  = 0;
        checked     = 0;
        cycle_count = 0;
        sent        = 0;
        n_done = 0; n_not_found = 0; n_empty = 0; n_full = 0;

        rows.push_back(make_row(MODE_DELETE, 5, 0, 0, 1, STATUS_EMPTY, 0));
        rows.push_back(make_row(MODE_CHANGE, 5, 6, 0, 1, STATUS_EMPTY, 0));
        rows.push_back(make_row(MODE_INSERT, 32'h7fff_ffff, 0, 32'hffff_ffff, 1, STATUS_DONE, 1));
        rows.push_back(make_row(MODE_INSERT, 32'h8000_0000, 0, 0, 1, STATUS_DONE, 2));
        rows.push_back(make_row(MODE_INSERT, 0, 0, 32'h5555_aaaa, 1, STATUS_DONE, 3));
        rows.push_back(make_row(MODE_INSERT, 0, 0, 32'haaaa_5555, 1, STATUS_DONE, 4));
        rows.push_back(make_row(MODE_INSERT, 32'hffff_ffff, 0, 1, 1, STATUS_DONE, 5));
        rows.push_back(make_row(MODE_DELETE, 7, 0, 0, 1, STATUS_NOT_FOUND, 5));
        rows.push_back(make_row(MODE_CHANGE, 7, 8, 0, 1, STATUS_NOT_FOUND, 5));
        rows.push_back(make_row(MODE_CHANGE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, STATUS_DONE, 0));
        rows.push_back(make_row(MODE_CHANGE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, STATUS_DONE, 0));
        rows.push_back(make_row(MODE_DELETE, 0, 0, 0, 1, STATUS_DONE, 4));
        rows.push_back(make_row(MODE_DELETE, 32'h7fff_ffff, 0, 0, 1, STATUS_DONE, 3));
        rows.push_back(make_row(MODE_CHANGE, 32'hffff_ffff, 32'h0, 0, 0, STATUS_DONE, 0));
        rows.push_back(make_row(MODE_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, STATUS_DONE, 0));
        rows.push_back(make_row(MODE_DELETE, 0, 0, 0, 1, STATUS_EMPTY, 0));
        rows.push_back(make_row(MODE_INSERT, 3, 0, 3, 1, STATUS_DONE, 1));

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        foreach (rows[i])
            predict_and_send(rows[i]);

        // Fill to capacity, refuse, then empty again.
        for (int i = 0; i < CAPACITY + 3; i++)
        begin
            if (i == 40)
                fork
                begin
                    stall_hold <= 1'b1;
                    repeat (3000) @(posedge clk);
                    stall_hold <= 1'b0;
                end
                join_none
            c.mode = MODE_INSERT;
            c.key = pick_key();
            c.new_key = $urandom();
            c.payload = $urandom();
            predict_and_send('{c, 1'b0, '0});
        end
        for (int i = 0; i < 20; i++)
        begin
            c.mode = (i % 2) ? MODE_CHANGE : MODE_DELETE;
            c.key = pick_key();
            c.new_key = pick_key();
            c.payload = $urandom();
            predict_and_send('{c, 1'b0, '0});
        end
        c.mode = MODE_CLEAR;
        predict_and_send('{c, 1'b0, '0});

        for (int i = 0; i < 850; i++)
        begin
            if (i == 720)
                quiet = 1'b1;
            mode_sel = $urandom_range(0, 99);
            if (mode_sel < 45)
                c.mode = MODE_INSERT;
            else if (mode_sel < 70)
                c.mode = MODE_DELETE;
            else if (mode_sel < 98)
                c.mode = MODE_CHANGE;
            else
                c.mode = MODE_CLEAR;
            c.key = pick_key();
            c.new_key = pick_key();
            c.payload = $urandom();
            predict_and_send('{c, 1'b0, '0});
        end
        req.valid <= 1'b0;

        while (answer_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("%0d commands, %0d responses: done %0d, not found %0d, empty %0d, full %0d",
                 sent, checked, n_done, n_not_found, n_empty, n_full);
        if (mismatches == 0 && answer_queue.size() == 0)
            $display("tb_sorted_linked_table_with_free_list passed");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("tb_sorted_linked_table_with_free_list failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_if.sv
rtl/slt_ram.sv
rtl/sorted_linked_table_with_free_list.sv
dv/tb_sorted_linked_table_with_free_list.sv
